@@ rtl/scp_pkg.sv @@
// ----------------------------------------------------------------------------
// scp_pkg
// shared constants and types of the spectrum column painter
// ----------------------------------------------------------------------------
package scp_pkg;

	localparam int HEIGHT      = 64;
	localparam int TABLE_DEPTH = 64;
	localparam int ROW_W       = 6;
	localparam int CH_W        = 8;
	localparam int RGBA_W      = 4 * CH_W;
	localparam int SAMPLE_W    = 16;
	localparam int PROD_W      = SAMPLE_W + ROW_W + 1;

	// stream payload layout
	localparam int S_TDATA_W = 56;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 40;

	typedef enum logic [1:0] {
		OP_PAINT   = 2'd0,
		OP_LOAD_BG = 2'd1,
		OP_LOAD_FG = 2'd2
	} scp_op_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_PAINT = 1'b1
	} scp_state_t;

	// per-pixel control that travels beside the table read
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic             sel_fg;
		logic             trace;
		logic             last;
	} scp_pix_ctl_t;

endpackage

@@ rtl/scp_ram.sv @@
// ----------------------------------------------------------------------------
// scp_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module scp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds while re is low
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/spectrum_column_painter.sv @@
// ----------------------------------------------------------------------------
// spectrum_column_painter
// paints one column of a spectrum display from two colour tables per sample
// ----------------------------------------------------------------------------
//
// channel  dir  tdata                                  tuser / tlast
// s_*      in   row, red, green, blue, alpha, sample   tuser: opcode, first_column
// m_*      out  pixel_row, out_red/green/blue/alpha    tlast: last_pixel
//
// a load item writes one table row
// a paint item holds the input while the row sequencer reads one row per
// cycle, unless a low m_tready holds it, from both tables through their
// single read ports; each pixel passes the registered table read and then
// the output register
// reset clears the sequencer and the previous level; the tables are not
// cleared and must be loaded before they are painted from
// a low m_tready holds the output register, which freezes the read stage and
// the row sequencer; s_tready is low while a column is being read
//
module spectrum_column_painter (
	input  logic                         clk,
	input  logic                         arst_n,
	// input items
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// [5:0] row, [13:6] red, [21:14] green, [29:22] blue, [37:30] alpha,
	// [53:38] sample, [55:54] zero
	input  logic [scp_pkg::S_TDATA_W-1:0] s_tdata,
	// [1:0] opcode, [2] first_column
	input  logic [scp_pkg::S_TUSER_W-1:0] s_tuser,
	// result items
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [5:0] pixel_row, [13:6] out_red, [21:14] out_green, [29:22] out_blue,
	// [37:30] out_alpha, [39:38] zero
	output logic [scp_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                         m_tlast
);

	import scp_pkg::*;

	// input field unpacking
	logic [ROW_W-1:0]    in_row;
	logic [RGBA_W-1:0]   in_rgba;
	logic [SAMPLE_W-1:0] in_sample;
	scp_op_t             in_op;
	logic                in_first;

	assign in_row    = s_tdata[ROW_W-1:0];
	assign in_rgba   = s_tdata[ROW_W +: RGBA_W];
	assign in_sample = s_tdata[ROW_W+RGBA_W +: SAMPLE_W];
	assign in_op     = scp_op_t'(s_tuser[1:0]);
	assign in_first  = s_tuser[2];

	logic in_accept;
	assign in_accept = s_tvalid && s_tready;

	// sequencer state
	scp_state_t       state_q, state_d;
	logic [ROW_W-1:0] y_q;
	logic [ROW_W-1:0] level_q, lo_q, hi_q, prev_level_q;
	logic             paint_start;
	logic             issue;
	logic             y_last;

	// level = sample * HEIGHT / 65536, always below HEIGHT
	logic [PROD_W-1:0] prod;
	logic [ROW_W-1:0]  level;
	logic [ROW_W-1:0]  prev_eff;

	assign prod     = PROD_W'(in_sample) * PROD_W'(HEIGHT);
	assign level    = prod[SAMPLE_W +: ROW_W];
	assign prev_eff = in_first ? level : prev_level_q;

	// read stage and output register
	logic         s1_valid_s1;
	scp_pix_ctl_t ctl_s1;
	logic         m_valid_q;
	logic         m_adv;
	logic         s1_free;

	assign m_adv   = !m_valid_q || m_tready;
	assign s1_free = !s1_valid_s1 || m_adv;
	assign y_last  = (y_q == ROW_W'(HEIGHT - 1));

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		issue       = 1'b0;
		paint_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && in_op == OP_PAINT) begin
					paint_start = 1'b1;
					state_d     = ST_PAINT;
				end
			end
			ST_PAINT: begin
				issue = s1_free;
				if (issue && y_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_q          <= '0;
			level_q      <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			prev_level_q <= '0;
		end else begin
			if (paint_start) begin
				// trace runs between the previous and the current level
				y_q          <= '0;
				level_q      <= level;
				lo_q         <= (prev_eff < level) ? prev_eff : level;
				hi_q         <= (prev_eff < level) ? level : prev_eff;
				prev_level_q <= level;
			end else if (issue) begin
				y_q <= y_q + ROW_W'(1);
			end
		end
	end

	// colour tables
	logic [RGBA_W-1:0] bg_rdata, fg_rdata;
	logic              we_bg, we_fg;

	assign we_bg = in_accept && in_op == OP_LOAD_BG;
	assign we_fg = in_accept && in_op == OP_LOAD_FG;

	scp_ram #(.WIDTH(RGBA_W), .DEPTH(TABLE_DEPTH)) u_bg_ram (
		.clk   (clk),
		.we    (we_bg),
		.waddr (in_row),
		.wdata (in_rgba),
		.re    (issue),
		.raddr (y_q),
		.rdata (bg_rdata)
	);

	scp_ram #(.WIDTH(RGBA_W), .DEPTH(TABLE_DEPTH)) u_fg_ram (
		.clk   (clk),
		.we    (we_fg),
		.waddr (in_row),
		.wdata (in_rgba),
		.re    (issue),
		.raddr (y_q),
		.rdata (fg_rdata)
	);

	// read stage: control lines up with the registered table data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s1_free) begin
			s1_valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ctl_s1.row    <= y_q;
			ctl_s1.sel_fg <= (y_q >= level_q);
			ctl_s1.trace  <= (y_q >= lo_q) && (y_q <= hi_q);
			ctl_s1.last   <= y_last;
		end
	end

	// pixel colour: table pick, then rgb forced to full on the trace
	logic [RGBA_W-1:0] pix_word;

	always_comb begin
		pix_word = ctl_s1.sel_fg ? fg_rdata : bg_rdata;
		if (ctl_s1.trace) begin
			pix_word[3*CH_W-1:0] = '1;
		end
	end

	// output register
	logic [M_TDATA_W-1:0] m_data_q;
	logic                 m_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (m_adv) begin
			m_valid_q <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_adv && s1_valid_s1) begin
			m_data_q <= {(M_TDATA_W - ROW_W - RGBA_W)'(0), pix_word, ctl_s1.row};
			m_last_q <= ctl_s1.last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

endmodule

@@ rtl/scp_checker.sv @@
// ----------------------------------------------------------------------------
// scp_checker
// port-level checks of the spectrum column painter
// ----------------------------------------------------------------------------
module scp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [scp_pkg::S_TUSER_W-1:0] s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [scp_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tlast
);

	import scp_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result item changed");

	// a paint item blocks the input right after it is taken
	a_paint_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[1:0] == OP_PAINT |=> !s_tready)
		else $error("input taken right after a paint item");

	// the last pixel of a column sits on the top row
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[ROW_W-1:0] == ROW_W'(HEIGHT - 1))
		else $error("last pixel not on the top row");

	// padding bits of the result stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_TDATA_W-1:ROW_W+RGBA_W] == '0)
		else $error("result padding not zero");

endmodule

bind spectrum_column_painter scp_checker u_scp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

@@ bench/tb_spectrum_column_painter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spectrum_column_painter
// self-checking bench: fills both colour tables, runs directed and random
// paint/load traffic with random gaps and back-pressure on both streams,
// and checks every emitted pixel against a column predictor in a scoreboard
// ----------------------------------------------------------------------------
module tb_spectrum_column_painter;
	import scp_pkg::*;

	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam int         N_RANDOM   = 350;

	// laid out like {m_tlast, m_tdata[37:0]}
	typedef struct packed {
		logic             last;
		logic [CH_W-1:0]  alpha;
		logic [CH_W-1:0]  blue;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  red;
		logic [ROW_W-1:0] row;
	} pixel_t;

	// column predictor and store of pixels still owed by the block
	class column_scoreboard;
		logic [RGBA_W-1:0] bg_rgba [TABLE_DEPTH];
		logic [RGBA_W-1:0] fg_rgba [TABLE_DEPTH];
		logic [ROW_W-1:0]  prev_level;
		pixel_t            pixel_q [$];
		int                errors;

		function new();
			prev_level = '0;
			errors     = 0;
		endfunction

		function int pending();
			return pixel_q.size();
		endfunction

		function void note_item(logic [1:0] op, logic first_col, logic [ROW_W-1:0] row,
				logic [RGBA_W-1:0] rgba, logic [SAMPLE_W-1:0] sample);
			logic [ROW_W-1:0]  level;
			logic [ROW_W-1:0]  lo;
			logic [ROW_W-1:0]  hi;
			logic [RGBA_W-1:0] word;
			pixel_t            px;
			case (op)
				OP_LOAD_BG: bg_rgba[row] = rgba;
				OP_LOAD_FG: fg_rgba[row] = rgba;
				OP_PAINT: begin
					level = ROW_W'((32'(sample) * HEIGHT) >> SAMPLE_W);
					// first column of a frame: no link to the previous trace
					if (first_col)
						prev_level = level;
					lo = (prev_level < level) ? prev_level : level;
					hi = (prev_level < level) ? level : prev_level;
					for (int y = 0; y < HEIGHT; y++) begin
						word = (y < level) ? bg_rgba[y] : fg_rgba[y];
						// trace rows go white but keep their alpha
						if (y >= lo && y <= hi)
							word[3*CH_W-1:0] = '1;
						px.row   = ROW_W'(y);
						px.red   = word[CH_W-1:0];
						px.green = word[2*CH_W-1:CH_W];
						px.blue  = word[3*CH_W-1:2*CH_W];
						px.alpha = word[4*CH_W-1:3*CH_W];
						px.last  = (y == HEIGHT - 1);
						pixel_q.push_back(px);
					end
					prev_level = level;
				end
				default: ; // unused opcode leaves everything alone
			endcase
		endfunction

		function void report(string what, int exp_val, int act_val);
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, what, exp_val, act_val);
		endfunction

		function void check_pixel(logic [M_TDATA_W-1:0] tdata, logic tlast);
			pixel_t got;
			pixel_t exp_px;
			got = {tlast, tdata[RGBA_W+ROW_W-1:0]};
			if (pixel_q.size() == 0) begin
				report("unexpected pixel, row", 0, got.row);
				return;
			end
			exp_px = pixel_q.pop_front();
			if (got.row !== exp_px.row)
				report("pixel row", exp_px.row, got.row);
			if (got.red !== exp_px.red)
				report($sformatf("row %0d red", exp_px.row), exp_px.red, got.red);
			if (got.green !== exp_px.green)
				report($sformatf("row %0d green", exp_px.row), exp_px.green, got.green);
			if (got.blue !== exp_px.blue)
				report($sformatf("row %0d blue", exp_px.row), exp_px.blue, got.blue);
			if (got.alpha !== exp_px.alpha)
				report($sformatf("row %0d alpha", exp_px.row), exp_px.alpha, got.alpha);
			if (got.last !== exp_px.last)
				report($sformatf("row %0d last", exp_px.row), exp_px.last, got.last);
		endfunction
	endclass

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [S_TUSER_W-1:0] s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;
	// no gaps on either side while set
	logic                 calm     = 1'b0;

	column_scoreboard sb;

	spectrum_column_painter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly back to back, often a short pause, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input logic [1:0] op, input logic first_col,
			input logic [ROW_W-1:0] row, input logic [RGBA_W-1:0] rgba,
			input logic [SAMPLE_W-1:0] sample);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  = {2'b00, sample, rgba, row};
		s_tuser  = {first_col, op};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_item(op, first_col, row, rgba, sample);
		@(negedge clk);
	endtask

	task automatic send_load(input logic [1:0] op, input logic [ROW_W-1:0] row,
			input logic [RGBA_W-1:0] rgba);
		send_item(op, 1'($urandom), row, rgba, SAMPLE_W'($urandom));
	endtask

	task automatic send_paint(input logic [SAMPLE_W-1:0] sample, input logic first_col);
		send_item(OP_PAINT, first_col, ROW_W'($urandom), RGBA_W'($urandom), sample);
	endtask

	// result side back-pressure
	initial begin
		int hold;
		int gap;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (calm) begin
				m_tready = 1'b1;
				hold     = 0;
			end else if (hold > 0) begin
				hold--;
			end else if (m_tready) begin
				gap = pick_gap();
				if (gap > 0) begin
					m_tready = 1'b0;
					hold     = gap - 1;
				end else begin
					hold = $urandom_range(0, 8);
				end
			end else begin
				m_tready = 1'b1;
				hold     = $urandom_range(0, 16);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_pixel(m_tdata, m_tlast);

	initial begin
		int          r;
		logic [15:0] sample;
		sb = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fill both tables so that no paint reads an unwritten entry
		for (int y = 0; y < TABLE_DEPTH; y++) begin
			send_load(OP_LOAD_BG, ROW_W'(y), RGBA_W'($urandom));
			send_load(OP_LOAD_FG, ROW_W'(y), RGBA_W'($urandom));
		end

		// first paint since reset, no first-column flag: trace runs up from row 0
		send_paint(16'h2000, 1'b0);
		// channel extremes at the table ends
		send_load(OP_LOAD_BG, 6'd0, 32'h0000_0000);
		send_load(OP_LOAD_FG, 6'd0, 32'hFFFF_FFFF);
		send_load(OP_LOAD_BG, 6'd63, 32'hFFFF_FFFF);
		send_load(OP_LOAD_FG, 6'd63, 32'h0000_0000);
		// unused opcode must not touch anything
		send_item(OP_UNUSED, 1'b1, 6'h3F, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(OP_UNUSED, 1'b0, ROW_W'($urandom), RGBA_W'($urandom), 16'h0000);
		// level extremes, fresh frames and full-height trace links both ways
		send_paint(16'h0000, 1'b1);
		send_paint(16'hFFFF, 1'b0);
		send_paint(16'hFFFF, 1'b1);
		send_paint(16'h0000, 1'b0);
		// level step boundaries
		send_paint(16'h03FF, 1'b0);
		send_paint(16'h0400, 1'b0);
		send_paint(16'hFC00, 1'b0);
		send_paint(16'hFBFF, 1'b0);
		send_load(OP_LOAD_BG, 6'd31, 32'h8080_8080);
		send_load(OP_LOAD_FG, 6'd31, 32'h7F7F_7F7F);
		send_paint(16'h7C00, 1'b1);
		send_item(OP_UNUSED, 1'b1, 6'd31, 32'h0000_0000, 16'h0000);
		send_paint(16'h8000, 1'b0);

		for (int i = 0; i < N_RANDOM; i++) begin
			calm = (i >= 150 && i < 230);
			r    = $urandom_range(0, 99);
			if (r < 50) begin
				sample = SAMPLE_W'($urandom);
				// sometimes land right on a level boundary
				if ($urandom_range(0, 9) == 0)
					sample = {sample[15:10], {10{sample[0]}}};
				send_paint(sample, $urandom_range(0, 99) < 15);
			end else if (r < 72) begin
				send_load(OP_LOAD_BG, ROW_W'($urandom), RGBA_W'($urandom));
			end else if (r < 95) begin
				send_load(OP_LOAD_FG, ROW_W'($urandom), RGBA_W'($urandom));
			end else begin
				send_item(OP_UNUSED, 1'($urandom), ROW_W'($urandom), RGBA_W'($urandom),
					SAMPLE_W'($urandom));
			end
		end
		calm     = 1'b0;
		s_tvalid = 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		// room for any stray pixel beyond the last column
		repeat (3 * HEIGHT) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog, far beyond a run where every pixel meets the longest stall
	initial begin
		#60_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
